// ===== src/memory_trace_line_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// memory trace line parser assertion macros
// shared assertion forms for the parser core
// ----------------------------------------------------------------------------
`ifndef MEMORY_TRACE_LINE_PARSER_CORE_MACROS_SVH
`define MEMORY_TRACE_LINE_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define MTLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mtlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtlp_pkg
// types and constants for the memory trace line parser
// ----------------------------------------------------------------------------
package mtlp_pkg;

    localparam int ADDR_BITS = 64;
    localparam int ADDR_W    = 64;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_X     = 8'd120;

    localparam logic [3:0] SIZE_WITH_FIELD = 4'd8;
    localparam logic [3:0] SIZE_NONE       = 4'd0;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_TID,
        PH_GAP,
        PH_ABLK,
        PH_AX,
        PH_AFIRST,
        PH_ADIG,
        PH_SBLK,
        PH_SX,
        PH_SFIRST,
        PH_SDIG,
        PH_IDLE
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY,
        ST_DONE,
        ST_FAIL
    } t_status;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_FREE,
        K_INSTR,
        K_READ,
        K_MODFY,
        K_WRITE,
        K_STACK
    } t_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        record_kind;
        logic [ADDR_W-1:0] address;
        logic [3:0]        access_size;
    } t_out_word;

    typedef struct packed {
        logic       blank;
        logic       dec;
        logic       hex;
        logic       zero;
        logic       ex;
        logic       closing;
        logic [3:0] hex_val;
        logic       kind_ok;
        t_kind      kind;
    } t_char_class;

    function automatic logic kind_no_size(input t_kind k);
        return (k == K_FREE) || (k == K_STACK);
    endfunction

endpackage

// ===== src/memory_trace_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// memory_trace_line_parser_core
// parses memory trace text into kind, address and size records
// ----------------------------------------------------------------------------
// Takes one byte of trace text per cycle and keeps taking one per cycle
// while the result side drains. A byte is held in the input register, goes
// through one parse step, and a finished record lands in the result register
// when the byte that closes its line (newline or line_end) steps. Comment,
// blank and malformed lines give no record. Only a full result register with
// the consumer not ready stalls the input.
module memory_trace_line_parser_core
    import mtlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_result
);

    `include "memory_trace_line_parser_core_macros.svh"

    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        out_free;
    logic        fire;
    logic        emit;
    t_char_class cls;
    t_out_word   step_result;

    assign fire    = r_in_valid && out_free;
    assign o_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word <= i_item;
        end
    end

    mtlp_char_class u_class (
        .i_word  (r_in_word),
        .o_class (cls)
    );

    mtlp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (fire),
        .i_class  (cls),
        .o_emit   (emit),
        .o_result (step_result)
    );

    mtlp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && emit),
        .i_word  (step_result),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_word  (o_result),
        .o_free  (out_free)
    );

    `MTLP_ASSERT_NOW(a_size_matches_kind, o_valid, (o_result.access_size == SIZE_NONE) == (o_result.record_kind == K_FREE || o_result.record_kind == K_STACK), "size does not match kind")
    `MTLP_ASSERT_NOW(a_kind_in_range, o_valid, o_result.record_kind <= K_STACK, "record kind out of range")
    `MTLP_ASSERT_NEXT(a_emit_lands, fire && emit, o_valid, "emitted record not presented")
    `MTLP_ASSERT_NEXT(a_stalled_word_kept, r_in_valid && !out_free, r_in_valid, "stalled word dropped")

endmodule

// ===== src/mtlp_char_class.sv =====
// ----------------------------------------------------------------------------
// mtlp_char_class
// classifies one trace byte: blanks, digits, hex value, type letter
// ----------------------------------------------------------------------------
module mtlp_char_class
    import mtlp_pkg::*;
(
    input  t_in_word    i_word,
    output t_char_class o_class
);

    logic [7:0] ch;
    logic [7:0] lower;
    logic       is_dec;
    logic       is_af;

    assign ch     = i_word.char_code;
    assign lower  = ch | 8'h20;
    assign is_dec = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_af  = (lower >= 8'h61) && (lower <= 8'h66);

    always_comb begin
        o_class         = '0;
        o_class.blank   = (ch == CH_SPACE) || (ch == CH_TAB);
        o_class.dec     = is_dec;
        o_class.hex     = is_dec || is_af;
        o_class.zero    = (ch == CH_ZERO);
        o_class.ex      = (ch == CH_X);
        o_class.closing = (ch == CH_NL) || i_word.line_end;
        o_class.hex_val = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
        o_class.kind_ok = 1'b1;
        o_class.kind    = K_ALLOC;
        unique case (lower)
            8'h61: o_class.kind = K_ALLOC;
            8'h66: o_class.kind = K_FREE;
            8'h69: o_class.kind = K_INSTR;
            8'h6c, 8'h72: o_class.kind = K_READ;
            8'h6d: o_class.kind = K_MODFY;
            8'h73, 8'h77: o_class.kind = K_WRITE;
            8'h70: o_class.kind = K_STACK;
            default: o_class.kind_ok = 1'b0;
        endcase
    end

endmodule

// ===== src/mtlp_parser.sv =====
// ----------------------------------------------------------------------------
// mtlp_parser
// line parse state and the per-byte step, one byte per advance
// ----------------------------------------------------------------------------
module mtlp_parser
    import mtlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_char_class i_class,
    output logic        o_emit,
    output t_out_word   o_result
);

    t_phase                 r_phase, n_phase;
    t_status                r_status, n_status;
    t_kind                  r_kind, n_kind;
    logic [ADDR_BITS-1:0]   r_acc, n_acc;
    logic [ADDR_BITS-1:0]   r_held, n_held;

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_held   = r_held;
        o_emit   = 1'b0;

        if (r_status == ST_BUSY) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (i_class.dec) begin
                        n_phase = PH_TID;
                    end else if (!i_class.blank) begin
                        n_status = ST_FAIL;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_TID, PH_GAP: begin
                    if (r_phase == PH_TID && i_class.dec) begin
                        n_phase = PH_TID;
                    end else if (i_class.blank) begin
                        n_phase = PH_GAP;
                    end else if (i_class.kind_ok) begin
                        n_kind  = i_class.kind;
                        n_phase = PH_ABLK;
                    end else begin
                        n_status = ST_FAIL;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_ABLK, PH_SBLK: begin
                    if (i_class.zero) begin
                        n_phase = (r_phase == PH_ABLK) ? PH_AX : PH_SX;
                    end else if (!i_class.blank) begin
                        n_status = ST_FAIL;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_AX, PH_SX: begin
                    if (i_class.ex) begin
                        n_phase = (r_phase == PH_AX) ? PH_AFIRST : PH_SFIRST;
                    end else begin
                        n_status = ST_FAIL;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_AFIRST: begin
                    if (i_class.hex) begin
                        n_acc   = ADDR_BITS'(i_class.hex_val);
                        n_phase = PH_ADIG;
                    end else begin
                        n_status = ST_FAIL;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_ADIG: begin
                    if (i_class.hex) begin
                        n_acc = {r_acc[ADDR_BITS-5:0], i_class.hex_val};
                    end else begin
                        n_held = r_acc;
                        if (kind_no_size(r_kind)) begin
                            n_status = ST_DONE;
                            n_phase  = PH_IDLE;
                        end else if (i_class.blank) begin
                            n_phase = PH_SBLK;
                        end else if (i_class.zero) begin
                            n_phase = PH_SX;
                        end else begin
                            n_status = ST_FAIL;
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                PH_SFIRST: begin
                    if (i_class.hex) begin
                        n_phase = PH_SDIG;
                    end else begin
                        n_status = ST_FAIL;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_SDIG: begin
                    if (!i_class.hex) begin
                        n_status = ST_DONE;
                        n_phase  = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_class.closing) begin
            if (n_status == ST_BUSY) begin
                if (n_phase == PH_ADIG && kind_no_size(n_kind)) begin
                    n_held   = n_acc;
                    n_status = ST_DONE;
                end else if (n_phase == PH_SDIG) begin
                    n_status = ST_DONE;
                end
            end
            o_emit   = (n_status == ST_DONE);
            n_phase  = PH_LEAD;
            n_acc    = '0;
            n_status = ST_BUSY;
        end
    end

    always_comb begin
        o_result.record_kind = n_kind;
        o_result.address     = ADDR_W'(n_held);
        o_result.access_size = kind_no_size(n_kind) ? SIZE_NONE : SIZE_WITH_FIELD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_status <= ST_BUSY;
            r_kind   <= K_ALLOC;
            r_acc    <= '0;
            r_held   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_kind   <= n_kind;
            r_acc    <= n_acc;
            r_held   <= n_held;
        end
    end

endmodule

// ===== src/mtlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// mtlp_out_stage
// result register with valid/ready toward the consumer
// ----------------------------------------------------------------------------
module mtlp_out_stage
    import mtlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    input  logic      i_ready,
    output logic      o_valid,
    output t_out_word o_word,
    output logic      o_free
);

    logic      r_valid;
    t_out_word r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the memory trace line parser core: a table of
// directed trace lines, then random well-formed, broken and noise lines,
// with every accepted word run through a local line predictor and each
// record compared field by field
// ----------------------------------------------------------------------------
module tb_top;
    import mtlp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_WORDS   = 1560;
    localparam int MIN_GOOD     = 40;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_SHOWN    = 10;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);
    localparam logic [7:0] NUL_MARK = "~";

    typedef enum {CHK_MODEL, CHK_NONE, CHK_REC} t_row_check;
    typedef enum {RX_OPEN, RX_COIN, RX_CHOKE, RX_LIGHT} t_rx_mode;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_result;

    t_in_word   word_q[$];
    int         tag_q[$];
    logic [7:0] line_q[$];
    t_out_word  typed_rec[$];
    bit         typed_has[$];
    t_out_word  expected_records[$];

    int cur_tag;
    int err_count;
    int good_lines;

    t_phase            scan_phase;
    t_status           line_state;
    logic [ADDR_W-1:0] digit_acc;
    logic [ADDR_W-1:0] rec_addr;
    t_kind             rec_kind;

    t_rx_mode rx_mode;
    int       rx_left;

    memory_trace_line_parser_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // line predictor
    // ------------------------------------------------------------------
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        return 5'd16;
    endfunction

    function automatic bit no_size_kind();
        return (rec_kind == K_FREE) || (rec_kind == K_STACK);
    endfunction

    function automatic void abort_line();
        line_state = ST_FAIL;
        scan_phase = PH_IDLE;
    endfunction

    function automatic void finish_line();
        line_state = ST_DONE;
        scan_phase = PH_IDLE;
    endfunction

    function automatic void classify_letter(input logic [7:0] c);
        case (c)
            "A", "a": rec_kind = K_ALLOC;
            "F", "f": rec_kind = K_FREE;
            "I", "i": rec_kind = K_INSTR;
            "L", "l", "R", "r": rec_kind = K_READ;
            "M", "m": rec_kind = K_MODFY;
            "S", "s", "W", "w": rec_kind = K_WRITE;
            "P", "p": rec_kind = K_STACK;
            default: begin
                abort_line();
                return;
            end
        endcase
        scan_phase = PH_ABLK;
    endfunction

    function automatic bit trace_step(input t_in_word w, output t_out_word rec);
        logic [7:0] c;
        logic [4:0] d;
        bit         blank;
        bit         dec;
        bit         closing;
        c       = w.char_code;
        d       = hex_val(c);
        blank   = (c == CH_SPACE) || (c == CH_TAB);
        dec     = (c >= "0") && (c <= "9");
        closing = (c == CH_NL) || w.line_end;
        rec     = '0;
        if (line_state == ST_BUSY) begin
            case (scan_phase)
                PH_LEAD: begin
                    if (dec) scan_phase = PH_TID;
                    else if (!blank) abort_line();
                end
                PH_TID: begin
                    if (!dec) begin
                        if (blank) scan_phase = PH_GAP;
                        else classify_letter(c);
                    end
                end
                PH_GAP: begin
                    if (!blank) classify_letter(c);
                end
                PH_ABLK: begin
                    if (c == CH_ZERO) scan_phase = PH_AX;
                    else if (!blank) abort_line();
                end
                PH_AX: begin
                    if (c == CH_X) scan_phase = PH_AFIRST;
                    else abort_line();
                end
                PH_AFIRST: begin
                    if (d < 16) begin
                        digit_acc  = ADDR_W'(d);
                        scan_phase = PH_ADIG;
                    end else begin
                        abort_line();
                    end
                end
                PH_ADIG: begin
                    if (d < 16) begin
                        digit_acc = ((digit_acc << 4) | ADDR_W'(d)) & ADDR_MASK;
                    end else begin
                        rec_addr = digit_acc & ADDR_MASK;
                        if (no_size_kind()) finish_line();
                        else if (blank) scan_phase = PH_SBLK;
                        else if (c == CH_ZERO) scan_phase = PH_SX;
                        else abort_line();
                    end
                end
                PH_SBLK: begin
                    if (c == CH_ZERO) scan_phase = PH_SX;
                    else if (!blank) abort_line();
                end
                PH_SX: begin
                    if (c == CH_X) scan_phase = PH_SFIRST;
                    else abort_line();
                end
                PH_SFIRST: begin
                    if (d < 16) scan_phase = PH_SDIG;
                    else abort_line();
                end
                PH_SDIG: begin
                    if (d >= 16) finish_line();
                end
                default: ;
            endcase
        end
        if (!closing) return 1'b0;
        if (line_state == ST_BUSY) begin
            if (scan_phase == PH_ADIG && no_size_kind()) begin
                rec_addr = digit_acc & ADDR_MASK;
                finish_line();
            end else if (scan_phase == PH_SDIG) begin
                finish_line();
            end
        end
        trace_step = (line_state == ST_DONE);
        if (trace_step) begin
            rec.record_kind = rec_kind;
            rec.address     = rec_addr;
            rec.access_size = no_size_kind() ? SIZE_NONE : SIZE_WITH_FIELD;
        end
        scan_phase = PH_LEAD;
        digit_acc  = '0;
        line_state = ST_BUSY;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic void queue_line(input bit end_flag, input int tag);
        t_in_word w;
        for (int i = 0; i < line_q.size(); i++) begin
            w.char_code = line_q[i];
            w.line_end  = (i == line_q.size() - 1) ? end_flag : 1'b0;
            word_q.push_back(w);
            tag_q.push_back((i == line_q.size() - 1) ? tag : -1);
        end
    endfunction

    function automatic void dir_row(input string txt, input bit end_flag,
                                    input t_row_check how, input t_kind k = K_ALLOC,
                                    input logic [63:0] a = '0, input logic [3:0] sz = '0);
        int tag;
        tag = -1;
        line_q.delete();
        for (int i = 0; i < txt.len(); i++) begin
            line_q.push_back((txt[i] == NUL_MARK) ? 8'h00 : txt[i]);
        end
        if (how != CHK_MODEL) begin
            typed_has.push_back(how == CHK_REC);
            typed_rec.push_back('{record_kind: k, address: a, access_size: sz});
            tag = typed_rec.size() - 1;
        end
        queue_line(end_flag, tag);
    endfunction

    function automatic void push_blanks(input int n);
        repeat (n) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void push_hex(input int n);
        string digits;
        digits = "0123456789abcdefABCDEF";
        line_q.push_back(CH_ZERO);
        line_q.push_back(CH_X);
        repeat (n) line_q.push_back(digits[$urandom_range(0, 21)]);
    endfunction

    function automatic bit make_line();
        string      letters;
        logic [7:0] letter;
        int         style;
        int         close;
        int         pos;
        bit         sized;
        letters = "AFILRMSWP";
        line_q.delete();
        style = $urandom_range(0, 9);
        if (style == 9) begin
            repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            push_blanks($urandom_range(0, 2));
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(7, 25) : $urandom_range(1, 4))
                line_q.push_back(8'("0" + $urandom_range(0, 9)));
            push_blanks($urandom_range(0, 2));
            letter = letters[$urandom_range(0, 8)];
            sized  = (letter != "F" && letter != "P") || ($urandom_range(0, 7) == 0);
            line_q.push_back($urandom_range(0, 1) ? (letter | 8'h20) : letter);
            push_blanks($urandom_range(0, 2));
            push_hex(($urandom_range(0, 7) == 0) ? $urandom_range(16, 24)
                                                  : $urandom_range(1, 16));
            if (sized) begin
                push_blanks($urandom_range(1, 2));
                push_hex($urandom_range(1, 3));
            end
            if ($urandom_range(0, 4) == 0) begin
                line_q.push_back(CH_SPACE);
                repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(33, 126)));
            end
            if (style >= 7) begin
                pos = $urandom_range(0, line_q.size() - 1);
                case ($urandom_range(0, 2))
                    0: line_q[pos] = 8'($urandom_range(0, 255));
                    1: line_q.delete(pos);
                    default: while (line_q.size() > pos) void'(line_q.pop_back());
                endcase
            end else begin
                good_lines++;
            end
        end
        close = $urandom_range(0, 9);
        if (close < 7 || close == 9 || line_q.size() == 0) line_q.push_back(CH_NL);
        return close >= 7;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic void note_error(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_word rec;
        t_out_word want;
        bit        got;
        if (i_rst_n && i_valid && o_ready) begin
            got = trace_step(i_item, rec);
            if (cur_tag >= 0) begin
                got = typed_has[cur_tag];
                rec = typed_rec[cur_tag];
            end
            if (got) expected_records.push_back(rec);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_records.size() == 0) begin
                note_error("unexpected word", '0, o_result.address);
            end else begin
                want = expected_records.pop_front();
                if (o_result.record_kind != want.record_kind)
                    note_error("record_kind", want.record_kind, o_result.record_kind);
                if (o_result.address != want.address)
                    note_error("address", want.address, o_result.address);
                if (o_result.access_size != want.access_size)
                    note_error("access_size", want.access_size, o_result.access_size);
            end
        end
    end

    // consumer stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:  i_ready <= 1'b1;
            RX_COIN:  i_ready <= ($urandom_range(0, 1) == 1);
            RX_CHOKE: i_ready <= ($urandom_range(0, 7) == 0);
            default:  i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : main
        bit       end_flag;
        int       burst_left;
        int       rand_words;
        t_in_word w;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_ready    = 1'b0;
        cur_tag    = -1;
        err_count  = 0;
        good_lines = 0;
        rx_mode    = RX_OPEN;
        rx_left    = 0;
        scan_phase = PH_LEAD;
        line_state = ST_BUSY;
        digit_acc  = '0;
        rec_addr   = '0;
        rec_kind   = K_ALLOC;

        // tilde stands for byte 0
        dir_row("  12 A 0x0 0x1\n", 0, CHK_REC, K_ALLOC, 64'h0, SIZE_WITH_FIELD);
        dir_row("3F0xffffffffffffffff\n", 0, CHK_REC, K_FREE, 64'hffff_ffff_ffff_ffff,
                SIZE_NONE);
        dir_row("\t7 i 0xDeadBeef 0x4\n", 0, CHK_MODEL);
        dir_row("1 L 0xabc 0x8\n", 0, CHK_REC, K_READ, 64'habc, SIZE_WITH_FIELD);
        dir_row("2 r 0x10 0x1\n", 0, CHK_REC, K_READ, 64'h10, SIZE_WITH_FIELD);
        dir_row("3 M 0x20 0xff\n", 0, CHK_REC, K_MODFY, 64'h20, SIZE_WITH_FIELD);
        dir_row("4 s 0x30 0x2\n", 0, CHK_REC, K_WRITE, 64'h30, SIZE_WITH_FIELD);
        dir_row("5 W 0x40 0x3\n", 0, CHK_REC, K_WRITE, 64'h40, SIZE_WITH_FIELD);
        dir_row("6 p 0x7fff\n", 0, CHK_REC, K_STACK, 64'h7fff, SIZE_NONE);
        dir_row("8 f 0x5", 1, CHK_REC, K_FREE, 64'h5, SIZE_NONE);
        dir_row("9 a 0x6 0x1", 1, CHK_REC, K_ALLOC, 64'h6, SIZE_WITH_FIELD);
        dir_row("9 L 0x6", 1, CHK_NONE);
        dir_row("2 F 0x44\n", 1, CHK_REC, K_FREE, 64'h44, SIZE_NONE);
        dir_row("1 L 1234 0x8\n", 0, CHK_NONE);
        dir_row("1 L 0X12 0x8\n", 0, CHK_NONE);
        dir_row("1 L 0x 0x8\n", 0, CHK_NONE);
        dir_row("1 S 0x9 0xg\n", 0, CHK_NONE);
        dir_row("1 M 0x1,0x2\n", 0, CHK_NONE);
        dir_row("# comment line\n", 0, CHK_NONE);
        dir_row("\n", 0, CHK_NONE);
        dir_row("  \t \n", 0, CHK_NONE);
        dir_row("1 Q 0x1 0x1\n", 0, CHK_NONE);
        dir_row("~1 A 0x1 0x1\n", 0, CHK_NONE);
        dir_row("1 A 0x1\377 0x1\n", 0, CHK_NONE);
        dir_row("5R0x10\t0x4 trailing junk\n", 0, CHK_MODEL);
        dir_row("1 W 0x123456789abcdef0123 0x8\n", 0, CHK_MODEL);
        dir_row("98765432109876543210987 I 0x1 0x1\r\n", 0, CHK_MODEL);

        rand_words = 0;
        while (rand_words < RAND_WORDS || good_lines < MIN_GOOD) begin
            end_flag = make_line();
            rand_words += line_q.size();
            queue_line(end_flag, -1);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        while (word_q.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
            w = word_q.pop_front();
            i_valid <= 1'b1;
            i_item  <= w;
            cur_tag <= tag_q.pop_front();
            burst_left--;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid <= 1'b0;

        while (expected_records.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
